/* rtl/ngfe_pkg.sv */
package ngfe_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [3:0] FIELDS = 4'd9;

  localparam logic [7:0] CAPTURE_WINDOW_RESET = 8'd55;

  localparam logic [2:0] HS_HUNT  = 3'd0;
  localparam logic [2:0] HS_SKIP1 = 3'd1;
  localparam logic [2:0] HS_SKIP2 = 3'd2;
  localparam logic [2:0] HS_G1    = 3'd3;
  localparam logic [2:0] HS_G2    = 3'd4;
  localparam logic [2:0] HS_A     = 3'd5;
  localparam logic [2:0] HS_COMMA = 3'd6;

  typedef struct packed {
    logic [2:0] header_stage;
    logic       capturing;
    logic [3:0] field_index;
    logic [3:0] position_in_field;
    logic [7:0] window_used;
  } gga_state_t;

  typedef struct packed {
    logic       emit;
    logic       char_valid;
    logic [3:0] field_number;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       record_done;
  } gga_result_t;

  // max characters kept per field: time, lat, N/S, lon, E/W, quality, sats, HDOP, alt
  function automatic logic [3:0] field_limit(input logic [3:0] idx);
    logic [3:0] lim;
    case (idx)
      4'd0: lim = 4'd9;
      4'd1: lim = 4'd11;
      4'd2: lim = 4'd1;
      4'd3: lim = 4'd12;
      4'd4: lim = 4'd1;
      4'd5: lim = 4'd1;
      4'd6: lim = 4'd2;
      4'd7: lim = 4'd3;
      4'd8: lim = 4'd7;
      default: lim = 4'd0;
    endcase
    return lim;
  endfunction

endpackage

/* rtl/ngfe_step.sv */
module ngfe_step
  import ngfe_pkg::*;
(
  input  gga_state_t  st,
  input  logic [7:0]  rx,
  input  logic [7:0]  capture_window,
  output gga_state_t  st_next,
  output gga_result_t res
);

  logic [8:0] used;
  logic [8:0] limit;
  logic [3:0] fidx_inc;
  logic       done;
  logic       valid;

  always_comb begin
    st_next  = st;
    res      = '0;
    done     = 1'b0;
    valid    = 1'b0;
    used     = {1'b0, st.window_used} + 9'd1;
    limit    = (capture_window == 8'd0) ? 9'd256 : {1'b0, capture_window};
    fidx_inc = st.field_index + 4'd1;

    if (!st.capturing) begin
      case (st.header_stage)
        HS_HUNT:  st_next.header_stage = (rx == CH_DOLLAR) ? HS_SKIP1 : HS_HUNT;
        HS_SKIP1: st_next.header_stage = HS_SKIP2;
        HS_SKIP2: st_next.header_stage = HS_G1;
        HS_G1:    st_next.header_stage = (rx == CH_G) ? HS_G2 : HS_HUNT;
        HS_G2:    st_next.header_stage = (rx == CH_G) ? HS_A : HS_HUNT;
        HS_A:     st_next.header_stage = (rx == CH_A) ? HS_COMMA : HS_HUNT;
        HS_COMMA: begin
          st_next                   = '0;
          st_next.capturing         = 1'b1;
        end
        default:  st_next.header_stage = HS_HUNT;
      endcase
    end else begin
      if (rx == CH_COMMA) begin
        st_next.field_index       = fidx_inc;
        st_next.position_in_field = 4'd0;
        if (fidx_inc >= FIELDS) begin
          done = 1'b1;
        end
      end else if (st.field_index < FIELDS) begin
        if (st.position_in_field < field_limit(st.field_index)) begin
          valid                     = 1'b1;
          st_next.position_in_field = st.position_in_field + 4'd1;
        end
      end else begin
        done = 1'b1;
      end

      if (used >= limit) begin
        done = 1'b1;
      end
      st_next.window_used = used[7:0];

      if (done) begin
        st_next = '0;
      end

      res.emit        = valid | done;
      res.char_valid  = valid;
      res.record_done = done;
      if (valid) begin
        res.field_number  = st.field_index;
        res.char_position = st.position_in_field;
        res.char_value    = rx;
      end
    end
  end

endmodule

/* rtl/nmea_gga_field_extractor.sv */
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_ready  | rx_byte
// out      | out_valid / out_ready| char_valid field_number char_position
//          |                      | char_value record_done
// cfg      | cfg_wr_en            | cfg_wr_data (capture_window)
//
// One byte per cycle unless output stalls: input register, parse logic, result register.
// A byte's result is registered once the result register is free or being taken.
// A byte that yields no result still updates the parser state and produces no transfer.
// Sync reset clears the parser to hunting and capture_window to 55.
// Output stall backs up into the input register, then in_ready drops.
module nmea_gga_field_extractor
  import ngfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       char_valid,
  output logic [3:0] field_number,
  output logic [3:0] char_position,
  output logic [7:0] char_value,
  output logic       record_done
);

  logic [7:0]  capture_window;
  logic [7:0]  rx_q;
  logic        rx_q_valid;
  gga_state_t  st;
  gga_state_t  st_next;
  gga_result_t res;
  gga_result_t out_q;
  logic        step_en;

  ngfe_step u_step (
    .st             (st),
    .rx             (rx_q),
    .capture_window (capture_window),
    .st_next        (st_next),
    .res            (res)
  );

  assign step_en  = rx_q_valid & (~out_valid | out_ready);
  assign in_ready = ~rx_q_valid | step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_window <= CAPTURE_WINDOW_RESET;
    end else if (cfg_wr_en) begin
      capture_window <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (in_ready) begin
      rx_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rx_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.emit) begin
      out_q <= res;
    end
  end

  assign char_valid    = out_q.char_valid;
  assign field_number  = out_q.field_number;
  assign char_position = out_q.char_position;
  assign char_value    = out_q.char_value;
  assign record_done   = out_q.record_done;

  a_capture_no_header: assert property (@(posedge clk) disable iff (rst)
    st.capturing |-> st.header_stage == HS_HUNT)
    else $error("header stage active while capturing");

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    st.capturing |-> st.field_index < FIELDS)
    else $error("field index out of range while capturing");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid || record_done))
    else $error("empty result presented");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (step_en && res.record_done) |=> !st.capturing)
    else $error("capture continued after record end");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |->
      (field_number == 4'd0 && char_position == 4'd0 && char_value == 8'd0))
    else $error("stale character fields on done-only result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import ngfe_pkg::*;
();

  localparam int IDLE_LIMIT = 4000;
  // per-field character caps, field 0 in the low nibble
  localparam logic [35:0] FIELD_CAPS = {4'd7, 4'd3, 4'd2, 4'd1, 4'd1, 4'd12, 4'd1, 4'd11, 4'd9};

  typedef struct packed {
    logic       char_valid;
    logic [3:0] field_number;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       record_done;
  } gga_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       char_valid;
  logic [3:0] field_number;
  logic [3:0] char_position;
  logic [7:0] char_value;
  logic       record_done;

  logic [7:0] tx_bytes[$];
  gga_char_t  exp_chars[$];
  int         queued_cnt = 0;
  int         err_cnt = 0;
  int         idle_cycles = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;

  // predictor state
  logic [7:0] m_win;
  logic [2:0] m_hs;
  logic       m_cap;
  logic [3:0] m_fidx;
  logic [3:0] m_pos;
  logic [7:0] m_used;

  nmea_gga_field_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_valid   (char_valid),
    .field_number (field_number),
    .char_position(char_position),
    .char_value   (char_value),
    .record_done  (record_done)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic parse_gga_byte(input logic [7:0] b);
    gga_char_t  r;
    logic [8:0] cnt;
    logic [8:0] lim9;
    logic       done;
    r = '0;
    done = 1'b0;
    if (!m_cap) begin
      case (m_hs)
        HS_HUNT:  m_hs = (b == CH_DOLLAR) ? HS_SKIP1 : HS_HUNT;
        HS_SKIP1: m_hs = HS_SKIP2;
        HS_SKIP2: m_hs = HS_G1;
        HS_G1:    m_hs = (b == CH_G) ? HS_G2 : HS_HUNT;
        HS_G2:    m_hs = (b == CH_G) ? HS_A : HS_HUNT;
        HS_A:     m_hs = (b == CH_A) ? HS_COMMA : HS_HUNT;
        HS_COMMA: begin
          m_hs = HS_HUNT;
          m_cap = 1'b1;
          m_fidx = 4'd0;
          m_pos = 4'd0;
          m_used = 8'd0;
        end
        default:  m_hs = HS_HUNT;
      endcase
    end else begin
      if (b == CH_COMMA) begin
        m_fidx = m_fidx + 4'd1;
        m_pos = 4'd0;
        if (m_fidx >= FIELDS) done = 1'b1;
      end else if (m_fidx < FIELDS) begin
        if (m_pos < FIELD_CAPS[m_fidx*4 +: 4]) begin
          r.char_valid = 1'b1;
          r.field_number = m_fidx;
          r.char_position = m_pos;
          r.char_value = b;
          m_pos = m_pos + 4'd1;
        end
      end else begin
        done = 1'b1;
      end
      cnt = {1'b0, m_used} + 9'd1;
      lim9 = (m_win == 8'd0) ? 9'd256 : {1'b0, m_win};
      if (cnt >= lim9) done = 1'b1;
      m_used = cnt[7:0];
      if (done) begin
        m_cap = 1'b0;
        m_hs = HS_HUNT;
        m_fidx = 4'd0;
        m_pos = 4'd0;
        m_used = 8'd0;
      end
      r.record_done = done;
      if (r.char_valid || done) exp_chars.push_back(r);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'd0;
      in_gap = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) in_calm = !in_calm;
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
          in_gap = in_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  // monitor: check result transfers, predict from input transfers
  always @(posedge clk) begin
    gga_char_t got;
    gga_char_t want;
    if (rst) begin
      m_win = CAPTURE_WINDOW_RESET;
      m_hs = HS_HUNT;
      m_cap = 1'b0;
      m_fidx = 4'd0;
      m_pos = 4'd0;
      m_used = 8'd0;
    end else begin
      if (out_valid && out_ready) begin
        got = {char_valid, field_number, char_position, char_value, record_done};
        if (exp_chars.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer got v=%0d f=%0d p=%0d c=%02h d=%0d", $time,
                   got.char_valid, got.field_number, got.char_position, got.char_value,
                   got.record_done);
        end else begin
          want = exp_chars.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display("%0t: exp v=%0d f=%0d p=%0d c=%02h d=%0d got v=%0d f=%0d p=%0d c=%02h d=%0d",
                     $time, want.char_valid, want.field_number, want.char_position,
                     want.char_value, want.record_done, got.char_valid, got.field_number,
                     got.char_position, got.char_value, got.record_done);
          end
        end
      end
      if (cfg_wr_en) m_win = cfg_wr_data;
      if (in_valid && in_ready) parse_gga_byte(rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued_cnt++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || in_valid || exp_chars.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input logic [7:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_field_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 90) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_sentence();
    string      hdr;
    int         r;
    int         k;
    int         n;
    logic [7:0] bad;
    hdr = "GGA";
    r = $urandom_range(0, 99);
    push_byte(CH_DOLLAR);
    if (r < 70) begin
      push_str("GP");
    end else begin
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 85) begin
      push_str(hdr);
    end else begin
      k = $urandom_range(0, 2);
      for (int i = 0; i < k; i++) push_byte(hdr[i]);
      bad = 8'($urandom_range(0, 255));
      if (bad == hdr[k]) bad = bad ^ 8'h01;
      push_byte(bad);
    end
    push_byte(CH_COMMA);
    for (int f = 0; f < 9; f++) begin
      if ($urandom_range(0, 9) == 0) n = FIELD_CAPS[f*4 +: 4] + $urandom_range(1, 3);
      else n = $urandom_range(0, FIELD_CAPS[f*4 +: 4]);
      for (int i = 0; i < n; i++) push_byte(rand_field_char());
      push_byte(CH_COMMA);
    end
    push_str("M,46.9,M,,*47\r\n");
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset window: broken header, over-long time, extreme bytes and header text in a field
    push_str("$GPGGB,");
    push_str("$GPGGA,123519.00x");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("$GPGGA,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");

    // one-byte window
    set_window(8'd1);
    push_str("$GNGGA,Z$GNGGA,,");

    // zero window spans 256 bytes
    set_window(8'd0);
    push_str("$GPGGA,,,,,,,,,");
    for (int i = 0; i < 250; i++) push_byte("7");
    push_str("X\r\n");

    // window shrunk below bytes already used mid-capture
    set_window(8'd55);
    push_str("$GPGGA,123456.00,4807.038");
    set_window(8'd5);
    push_str("12,N\r\n");

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: w = 8'd255;
        1: w = 8'd0;
        2: w = 8'd2;
        3: w = 8'd9;
        4: w = 8'd30;
        8: w = 8'd55;
        default: w = 8'($urandom_range(1, 255));
      endcase
      set_window(w);
      queued_cnt = 0;
      while (queued_cnt < 145) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_sentence();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && exp_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
